@@ rtl/core/dtf_pkg.sv @@
`default_nettype none

package dtf_pkg;

  // character codes the parser cares about
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // width of the fixed-point result port
  localparam int VALUE_W = 64;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_REAL = 2'd1,
    STATUS_BAD_IMAG = 2'd2,
    STATUS_SAT      = 2'd3
  } status_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH
  } back_state_t;

  // 10^n, used only at elaboration
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // bits needed for the fraction numerator and for 10^digits
  function automatic int acc_width(input int digits);
    return $clog2(pow10(digits) + 64'd1);
  endfunction

  // job word: bad, kind, negative, saturated, integer part, numerator, denominator
  function automatic int job_width(input int int_bits, input int digits);
    return 4 + int_bits + 2 * acc_width(digits);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dtf_queue.sv @@
`default_nettype none

module dtf_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  output logic                  valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // occupancy flags
  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_data = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dtf_front.sv @@
`default_nettype none

module dtf_front #(
  parameter int INT_BITS    = 31,
  parameter int FRAC_DIGITS = 9,
  localparam int JOB_W      = dtf_pkg::job_width(INT_BITS, FRAC_DIGITS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       char_code,
  input  wire logic             arg_kind,
  input  wire logic             q_full,
  output logic                  push,
  output logic [JOB_W-1:0]      job
);

  import dtf_pkg::*;

  localparam int ACC_W = acc_width(FRAC_DIGITS);
  localparam int CNT_W = $clog2(FRAC_DIGITS + 1);
  localparam logic [INT_BITS-1:0] INT_MAX = '1;

  typedef struct packed {
    logic                bad;
    logic                kind;
    logic                negative;
    logic                saturated;
    logic [INT_BITS-1:0] int_part;
    logic [ACC_W-1:0]    frac_num;
    logic [ACC_W-1:0]    frac_den;
  } job_t;

  logic [1:0]          char_position, char_position_next;
  logic                first_was_sign, first_was_sign_next;
  logic                negative, negative_next;
  logic                dot_seen, dot_seen_next;
  logic                malformed, malformed_next;
  logic [INT_BITS-1:0] integer_acc, integer_acc_next;
  logic                int_saturated, int_saturated_next;
  logic [ACC_W-1:0]    fraction_acc, fraction_acc_next;
  logic [ACC_W-1:0]    fraction_den, fraction_den_next;
  logic [CNT_W-1:0]    fraction_count, fraction_count_next;

  logic                accept;
  logic                is_digit;
  logic [3:0]          digit;
  logic [INT_BITS+3:0] int_times_ten;
  logic [ACC_W+3:0]    frac_times_ten;
  logic [ACC_W+3:0]    den_times_ten;
  logic                bad;
  job_t                job_out;

  // handshake
  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (char_code == CHAR_NUL);

  // digit decode and shift-add times ten
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = 4'(char_code - CHAR_ZERO);
  assign int_times_ten  = ((INT_BITS+4)'(integer_acc) << 3) + ((INT_BITS+4)'(integer_acc) << 1)
                        + (INT_BITS+4)'(digit);
  assign frac_times_ten = ((ACC_W+4)'(fraction_acc) << 3) + ((ACC_W+4)'(fraction_acc) << 1)
                        + (ACC_W+4)'(digit);
  assign den_times_ten  = ((ACC_W+4)'(fraction_den) << 3) + ((ACC_W+4)'(fraction_den) << 1);

  // syntax check at the terminating zero
  assign bad = malformed
            || (char_position == 2'd0)
            || ((char_position == 2'd1) && first_was_sign)
            || ((char_position == 2'd2) && first_was_sign && dot_seen);

  // job handed to the back end
  always_comb begin
    job_out.bad       = bad;
    job_out.kind      = arg_kind;
    job_out.negative  = negative;
    job_out.saturated = int_saturated;
    job_out.int_part  = integer_acc;
    job_out.frac_num  = fraction_acc;
    job_out.frac_den  = fraction_den;
  end
  assign job = job_out;

  // parser next state
  always_comb begin
    char_position_next  = char_position;
    first_was_sign_next = first_was_sign;
    negative_next       = negative;
    dot_seen_next       = dot_seen;
    malformed_next      = malformed;
    integer_acc_next    = integer_acc;
    int_saturated_next  = int_saturated;
    fraction_acc_next   = fraction_acc;
    fraction_den_next   = fraction_den;
    fraction_count_next = fraction_count;
    if (accept) begin
      if (char_code == CHAR_NUL) begin
        char_position_next  = 2'd0;
        first_was_sign_next = 1'b0;
        negative_next       = 1'b0;
        dot_seen_next       = 1'b0;
        malformed_next      = 1'b0;
        integer_acc_next    = '0;
        int_saturated_next  = 1'b0;
        fraction_acc_next   = '0;
        fraction_den_next   = ACC_W'(1);
        fraction_count_next = '0;
      end else begin
        if (char_position != 2'd3) begin
          char_position_next = char_position + 2'd1;
        end
        if (!malformed) begin
          if ((char_position == 2'd0) &&
              ((char_code == CHAR_PLUS) || (char_code == CHAR_MINUS))) begin
            first_was_sign_next = 1'b1;
            negative_next       = (char_code == CHAR_MINUS);
          end else if (char_code == CHAR_DOT) begin
            if (dot_seen) begin
              malformed_next = 1'b1;
            end
            dot_seen_next = 1'b1;
          end else if (is_digit) begin
            if (!dot_seen) begin
              if (int_times_ten > (INT_BITS+4)'(INT_MAX)) begin
                integer_acc_next   = INT_MAX;
                int_saturated_next = 1'b1;
              end else begin
                integer_acc_next = int_times_ten[INT_BITS-1:0];
              end
            end else if (fraction_count < CNT_W'(FRAC_DIGITS)) begin
              fraction_acc_next   = frac_times_ten[ACC_W-1:0];
              fraction_den_next   = den_times_ten[ACC_W-1:0];
              fraction_count_next = fraction_count + CNT_W'(1);
            end
          end else begin
            malformed_next = 1'b1;
          end
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= 2'd0;
      first_was_sign <= 1'b0;
      negative       <= 1'b0;
      dot_seen       <= 1'b0;
      malformed      <= 1'b0;
      integer_acc    <= '0;
      int_saturated  <= 1'b0;
      fraction_acc   <= '0;
      fraction_den   <= ACC_W'(1);
      fraction_count <= '0;
    end else begin
      char_position  <= char_position_next;
      first_was_sign <= first_was_sign_next;
      negative       <= negative_next;
      dot_seen       <= dot_seen_next;
      malformed      <= malformed_next;
      integer_acc    <= integer_acc_next;
      int_saturated  <= int_saturated_next;
      fraction_acc   <= fraction_acc_next;
      fraction_den   <= fraction_den_next;
      fraction_count <= fraction_count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dtf_back.sv @@
`default_nettype none

module dtf_back #(
  parameter int INT_BITS    = 31,
  parameter int FRAC_DIGITS = 9,
  parameter int FRAC_BITS   = 32,
  localparam int JOB_W      = dtf_pkg::job_width(INT_BITS, FRAC_DIGITS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              pop,
  input  wire logic [JOB_W-1:0]             job,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [dtf_pkg::VALUE_W-1:0] value,
  output dtf_pkg::status_t                  status
);

  import dtf_pkg::*;

  localparam int ACC_W  = acc_width(FRAC_DIGITS);
  localparam int STEP_W = $clog2(FRAC_BITS);

  typedef struct packed {
    logic                bad;
    logic                kind;
    logic                negative;
    logic                saturated;
    logic [INT_BITS-1:0] int_part;
    logic [ACC_W-1:0]    frac_num;
    logic [ACC_W-1:0]    frac_den;
  } job_t;

  back_state_t          state, state_next;
  job_t                 job_in;
  job_t                 cur;
  logic [ACC_W-1:0]     rem;
  logic [FRAC_BITS-1:0] quo;
  logic [STEP_W-1:0]    step_cnt;

  logic [ACC_W:0]       rem_shift;
  logic [ACC_W:0]       rem_sub;
  logic                 fits;
  logic                 last_step;
  logic                 out_free;
  logic                 load_out;
  logic [VALUE_W-1:0]   mag;
  logic [VALUE_W-1:0]   result_value;
  status_t              result_status;

  // queue head viewed as a job record
  assign job_in = job;

  // one restoring-division step per cycle
  assign rem_shift = {rem, 1'b0};
  assign fits      = (rem_shift >= {1'b0, cur.frac_den});
  assign rem_sub   = rem_shift - {1'b0, cur.frac_den};
  assign last_step = (step_cnt == STEP_W'(FRAC_BITS - 1));

  // assemble the signed fixed-point result
  assign mag = (VALUE_W'(cur.int_part) << FRAC_BITS) | VALUE_W'(quo);
  always_comb begin
    if (cur.bad) begin
      result_value  = '0;
      result_status = cur.kind ? STATUS_BAD_IMAG : STATUS_BAD_REAL;
    end else begin
      result_value  = cur.negative ? -mag : mag;
      result_status = cur.saturated ? STATUS_SAT : STATUS_OK;
    end
  end

  assign out_free = !out_valid || out_ready;

  // sequencer next state
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (last_step) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= job_in;
      rem      <= job_in.frac_num;
      quo      <= '0;
      step_cnt <= '0;
    end else if (state == BK_DIVIDE) begin
      rem      <= fits ? rem_sub[ACC_W-1:0] : rem_shift[ACC_W-1:0];
      quo      <= {quo[FRAC_BITS-2:0], fits};
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value  <= result_value;
      status <= result_status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/decimal_text_to_fixed_point_core.sv @@
// Decimal text to signed fixed-point converter.
// Input channel (in_valid/in_ready): one ASCII character per item in char_code,
// with arg_kind tagging the argument (0 real, 1 imaginary). A zero character
// ends the number and produces exactly one result; other characters produce none.
// Output channel (out_valid/out_ready): value is signed Q(INT_BITS).(FRAC_BITS),
// status is ok, malformed real, malformed imaginary or integer saturated.
// The front parser takes one character per cycle while the two-entry job queue
// has room. Each terminated number is scaled by a restoring divider that
// retires one quotient bit per cycle; a number passes from the job queue
// through the back end's idle, divide and finish states to the output register.
// The back end pops a new number only once its last result is in that register.
// Characters keep flowing while the divider works, up to two queued numbers.
// The result sits in an output register; if the receiver stalls, the divider
// holds its finished result and the queue then fills, after which in_ready drops.
// Synchronous reset clears the parser, the queue and the output valid; the
// block is ready for items as soon as reset is released.
`default_nettype none

module decimal_text_to_fixed_point_core #(
  parameter int FRAC_DIGITS = 9,
  parameter int INT_BITS    = 31,
  parameter int FRAC_BITS   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    char_code,
  input  wire logic                          arg_kind,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [dtf_pkg::VALUE_W-1:0] value,
  output dtf_pkg::status_t                   status
);

  import dtf_pkg::*;

  localparam int JOB_W = job_width(INT_BITS, FRAC_DIGITS);

  logic             q_push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [JOB_W-1:0] q_wr_data;
  logic [JOB_W-1:0] q_rd_data;

  // character parser
  dtf_front #(
    .INT_BITS    (INT_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .arg_kind  (arg_kind),
    .q_full    (q_full),
    .push      (q_push),
    .job       (q_wr_data)
  );

  // job queue between parser and divider
  dtf_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .rd_data (q_rd_data)
  );

  // fraction scaling and result assembly
  dtf_back #(
    .INT_BITS    (INT_BITS),
    .FRAC_DIGITS (FRAC_DIGITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop       (q_pop),
    .job       (q_rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  // a terminated number is queued or already taken by the back end
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> q_valid || !$past(q_valid))
    else $error("terminated number lost between parser and divider");

  // malformed results carry a zero value
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == STATUS_BAD_REAL) || (status == STATUS_BAD_IMAG))
      |-> (value == '0))
    else $error("malformed result with nonzero value");

  // a positive saturated result has its integer field at full scale
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_SAT) && !value[VALUE_W-1]
      |-> (&value[INT_BITS+FRAC_BITS-1:FRAC_BITS]))
    else $error("saturated result without full-scale integer part");

endmodule

`default_nettype wire

@@ test/dtf_result_checker.sv @@
`timescale 1ns / 1ps

module dtf_result_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [7:0]                    char_code,
  input  wire logic                          arg_kind,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic signed [dtf_pkg::VALUE_W-1:0] value,
  input  dtf_pkg::status_t                   status,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen
);
  import dtf_pkg::*;

  localparam int FRAC_DIGITS = 9;
  localparam int INT_BITS    = 31;
  localparam int FRAC_BITS   = 32;
  localparam int FRAC_ACC_W  = 30;
  localparam logic [63:0] INT_LIMIT = (64'd1 << INT_BITS) - 64'd1;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } number_result_t;

  // parser state of the number being collected
  logic [1:0]            pos_cnt;
  logic                  lead_sign;
  logic                  is_neg;
  logic                  has_dot;
  logic                  syntax_bad;
  logic [INT_BITS-1:0]   int_part;
  logic                  int_clipped;
  logic [FRAC_ACC_W-1:0] frac_part;
  logic [3:0]            frac_digits;

  number_result_t expected_numbers[$];
  int mismatches;
  int compared;

  function automatic void clear_number();
    pos_cnt     = '0;
    lead_sign   = 1'b0;
    is_neg      = 1'b0;
    has_dot     = 1'b0;
    syntax_bad  = 1'b0;
    int_part    = '0;
    int_clipped = 1'b0;
    frac_part   = '0;
    frac_digits = '0;
  endfunction

  // fold one non-terminating character into the number
  function automatic void absorb_char(input logic [7:0] c);
    logic [1:0]  pos_before;
    logic [63:0] widened;
    pos_before = pos_cnt;
    if (pos_cnt != 2'd3) pos_cnt = pos_cnt + 2'd1;
    if (syntax_bad) return;
    if (pos_before == 2'd0 && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      lead_sign = 1'b1;
      is_neg    = (c == CHAR_MINUS);
    end else if (c == CHAR_DOT) begin
      if (has_dot) syntax_bad = 1'b1;
      has_dot = 1'b1;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (!has_dot) begin
        widened = 64'(int_part) * 64'd10 + 64'(c - CHAR_ZERO);
        // integer part clips at the largest magnitude
        if (widened > INT_LIMIT) begin
          int_part    = '1;
          int_clipped = 1'b1;
        end else begin
          int_part = widened[INT_BITS-1:0];
        end
      end else if (frac_digits < 4'(FRAC_DIGITS)) begin
        frac_part   = FRAC_ACC_W'(64'(frac_part) * 64'd10 + 64'(c - CHAR_ZERO));
        frac_digits = frac_digits + 4'd1;
      end
    end else begin
      syntax_bad = 1'b1;
    end
  endfunction

  // terminator: work out the fixed-point result and start a new number
  function automatic number_result_t close_number(input logic kind);
    number_result_t r;
    logic           failed;
    logic [63:0]    den;
    logic [63:0]    rem;
    logic [63:0]    quo;
    logic [63:0]    mag;
    failed = syntax_bad || pos_cnt == 2'd0 || (pos_cnt == 2'd1 && lead_sign) ||
             (pos_cnt == 2'd2 && lead_sign && has_dot);
    if (failed) begin
      r.value  = '0;
      r.status = kind ? STATUS_BAD_IMAG : STATUS_BAD_REAL;
    end else begin
      den = 64'd1;
      for (int i = 0; i < frac_digits; i++) den = den * 64'd10;
      // restoring division, one quotient bit per step
      rem = 64'(frac_part);
      quo = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem    = rem - den;
          quo[0] = 1'b1;
        end
      end
      mag      = (64'(int_part) << FRAC_BITS) | quo;
      r.value  = is_neg ? -mag : mag;
      r.status = int_clipped ? STATUS_SAT : STATUS_OK;
    end
    clear_number();
    return r;
  endfunction

  initial begin
    clear_number();
    mismatches = 0;
    compared   = 0;
  end

  // watch both channels, predict on input items, compare on output items
  always @(posedge clk) begin
    number_result_t exp_r;
    if (rst) begin
      clear_number();
      expected_numbers.delete();
    end else begin
      if (out_valid && out_ready) begin
        compared++;
        if (expected_numbers.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected result %0d: value=%0d status=%0d", compared, value, status);
          mismatches++;
        end else begin
          exp_r = expected_numbers.pop_front();
          if (value !== exp_r.value || status !== exp_r.status) begin
            if (mismatches < REPORT_MAX)
              $display("mismatch on result %0d: expected value=%0d status=%0d, got value=%0d status=%0d",
                       compared, exp_r.value, exp_r.status, value, status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (char_code == CHAR_NUL) expected_numbers.push_back(close_number(arg_kind));
        else absorb_char(char_code);
      end
    end
    fail_count   <= mismatches;
    pending      <= expected_numbers.size();
    results_seen <= compared;
  end

endmodule

@@ test/decimal_text_to_fixed_point_core_tb.sv @@
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_core_tb;
  import dtf_pkg::*;

  localparam int          RANDOM_CHARS   = 850;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 60;
  localparam logic [7:0]  CHAR_SPACE     = 8'h20;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [7:0]                 char_code;
  logic                       arg_kind;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [VALUE_W-1:0]  value;
  status_t                    status;

  int fail_count;
  int pending;
  int results_seen;
  int chars_sent;
  int numbers_sent;
  int hold_request;
  bit calm;
  logic [7:0] text[$];

  always #10 clk = ~clk;

  decimal_text_to_fixed_point_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .arg_kind  (arg_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  dtf_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .arg_kind     (arg_kind),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // offer one character, with a random gap first
  task automatic send_char(input logic [7:0] c, input logic k);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    arg_kind  <= k;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    chars_sent++;
  endtask

  // send the collected text and its terminator
  task automatic send_text(input logic kind);
    foreach (text[i]) send_char(text[i], 1'($urandom_range(0, 1)));
    send_char(CHAR_NUL, kind);
    text.delete();
    numbers_sent++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  // number with random content, mostly well formed
  task automatic build_number();
    int r;
    case ($urandom_range(0, 3))
      0: text.push_back(CHAR_PLUS);
      1: text.push_back(CHAR_MINUS);
      default: ;
    endcase
    r = $urandom_range(0, 11);
    if (r == 0) add_digits($urandom_range(10, 12));
    else if (r == 1) push_str($urandom_range(0, 1) ? "2147483647" : "2147483648");
    else add_digits($urandom_range(0, 6));
    if ($urandom_range(0, 3) != 0) begin
      text.push_back(CHAR_DOT);
      add_digits($urandom_range(0, 11));
    end
  endtask

  // random number with one character after the first replaced, or one appended
  task automatic damage_number();
    int p;
    logic [7:0] b;
    build_number();
    if (text.size() == 0) add_digits(1);
    case ($urandom_range(0, 3))
      0: b = 8'($urandom_range(1, 255));
      1: b = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      2: b = CHAR_DOT;
      default: b = CHAR_SPACE;
    endcase
    p = $urandom_range(1, text.size());
    if (p == text.size()) text.push_back(b);
    else text[p] = b;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // watchdog on handshake activity
  initial begin
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item moved for %0d cycles, %0d results still due", quiet, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int start;
    int n;
    int sel;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    char_code    <= CHAR_NUL;
    arg_kind     <= 1'b0;
    calm         = 1'b0;
    hold_request = 0;
    chars_sent   = 0;
    numbers_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    send_text(1'b0);                       // empty number
    push_str("-");        send_text(1'b1); // lone sign
    push_str("+.");       send_text(1'b0); // sign then dot only
    push_str(".");        send_text(1'b1); // lone dot is zero
    push_str("-0");       send_text(1'b0); // negative zero
    push_str("..");       send_text(1'b1); // second dot
    text.push_back(8'hFF); send_text(1'b0); // bad character
    push_str(" 1");       send_text(1'b1); // whitespace
    push_str("-99999999999.1234567890"); send_text(1'b0); // clip, extra digits

    // random numbers, mostly well formed
    start = chars_sent;
    n = 0;
    while (chars_sent - start < RANDOM_CHARS) begin
      if (n == 20) hold_request = HOLD_CYCLES;
      if (n == 50) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      calm = (n >= 70 && n < 90);
      sel = $urandom_range(0, 9);
      if (sel < 7) build_number();
      else if (sel < 9) damage_number();
      else repeat ($urandom_range(0, 5)) text.push_back(8'($urandom_range(1, 255)));
      send_text(1'($urandom_range(0, 1)));
      n++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d characters forming %0d numbers, compared %0d results", chars_sent,
             numbers_sent, results_seen);
    $display("run covered syntax errors, clipping, long fractions, stalls and back-to-back input");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
